@@ rtl/srzp_pkg.sv @@
// ---------------------------------------------------------------------------
// srzp_pkg: shared types and constants of the sparse row zero pruner
// Item and result records, field widths, mode, kind and register codes.
// ---------------------------------------------------------------------------
package srzp_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned COL_W = 16;
  localparam int unsigned PTR_W = 17;
  localparam int unsigned ABS_W = 31;
  localparam int unsigned REL_W = 16;
  localparam int unsigned PROD_W = VAL_W + REL_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = ABS_W;
  localparam int unsigned IN_DATA_W = 48;
  localparam int unsigned OUT_DATA_W = 72;

  // pass selector
  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_FILTER = 1'b1;

  // result kind
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_ROWPTR = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ABS_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REL_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_BASED = 2'd2;

  // one input item after registering, with its magnitude
  typedef struct packed {
    logic mode;
    logic first;
    logic has_entry;
    logic signed [VAL_W-1:0] entry_value;
    logic [COL_W-1:0] column_index;
    logic row_end;
    logic [VAL_W-1:0] magnitude;
  } item_t;

  // one result item
  typedef struct packed {
    logic kind;
    logic signed [VAL_W-1:0] kept_value;
    logic [COL_W-1:0] kept_column;
    logic [PTR_W-1:0] row_pointer;
    logic last;
  } result_t;

  // tolerance status toward the emit stage
  typedef struct packed {
    logic stale;
    logic [VAL_W-1:0] tolerance;
  } tol_info_t;

endpackage

@@ rtl/srzp_in_stage.sv @@
// ---------------------------------------------------------------------------
// srzp_in_stage: input register with skid slot
// Registers accepted items, forms the entry magnitude, keeps tready registered.
// ---------------------------------------------------------------------------
module srzp_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [srzp_pkg::IN_DATA_W-1:0]      in_tdata,  // entry_value, column_index
  input  logic [2:0]                          in_tuser,  // mode, first, has_entry
  input  logic                                in_tlast,
  input  logic                                take,
  output logic                                item_vld,
  output srzp_pkg::item_t                     item
);

  srzp_pkg::item_t main_r, main_nxt;
  srzp_pkg::item_t skid_r;
  logic main_vld_r, main_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  srzp_pkg::item_t in_item;
  logic acc;

  // unpack the port and form the magnitude
  always_comb begin
    in_item.mode = in_tuser[0];
    in_item.first = in_tuser[1];
    in_item.has_entry = in_tuser[2];
    in_item.entry_value = in_tdata[srzp_pkg::VAL_W-1:0];
    in_item.column_index = in_tdata[srzp_pkg::VAL_W +: srzp_pkg::COL_W];
    in_item.row_end = in_tlast;
    in_item.magnitude = in_tdata[srzp_pkg::VAL_W-1] ?
                        (~in_tdata[srzp_pkg::VAL_W-1:0] + 32'd1) :
                        in_tdata[srzp_pkg::VAL_W-1:0];
  end

  assign in_tready = !skid_vld_r;
  assign acc = in_tvalid && in_tready;

  // main slot refills from skid first, then from the port
  always_comb begin
    main_nxt = main_r;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (take || !main_vld_r) begin
      main_nxt = skid_vld_r ? skid_r : in_item;
      main_vld_nxt = skid_vld_r || acc;
      skid_vld_nxt = 1'b0;
    end else if (acc) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    if (acc && main_vld_r && !take) begin
      skid_r <= in_item;
    end
  end

  assign item_vld = main_vld_r;
  assign item = main_r;

  // skid slot only fills behind a held main slot
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid slot valid with empty main slot");

endmodule

@@ rtl/srzp_tol_unit.sv @@
// ---------------------------------------------------------------------------
// srzp_tol_unit: maximum tracking and tolerance
// Keeps the scan maximum, registers rel * max, and forms the saturated sum.
// ---------------------------------------------------------------------------
module srzp_tol_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               scan_fire,
  input  srzp_pkg::item_t                    item,
  input  logic [srzp_pkg::ABS_W-1:0]         abs_tol,
  input  logic [srzp_pkg::REL_W-1:0]         rel_tol,
  input  logic                               cfg_we,
  output srzp_pkg::tol_info_t                tol_info
);

  logic [srzp_pkg::VAL_W-1:0] max_r, max_nxt, max_base;
  logic [srzp_pkg::PROD_W-1:0] prod_r;
  logic stale_r, stale_nxt;
  logic [srzp_pkg::VAL_W:0] tol_sum;

  // scan update: first item clears before compare
  always_comb begin
    max_base = item.first ? '0 : max_r;
    max_nxt = max_r;
    if (scan_fire) begin
      max_nxt = (item.has_entry && (item.magnitude > max_base)) ? item.magnitude : max_base;
    end
    stale_nxt = (max_nxt != max_r) || cfg_we;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
      stale_r <= 1'b1;
    end else begin
      max_r <= max_nxt;
      stale_r <= stale_nxt;
    end
  end

  // product register is loaded from max and lags it, covered by the stale flag
  always_ff @(posedge clk) begin
    prod_r <= srzp_pkg::PROD_W'(rel_tol) * srzp_pkg::PROD_W'(max_r);
  end

  // saturating tolerance sum
  assign tol_sum = {2'b00, abs_tol} + {1'b0, prod_r[srzp_pkg::PROD_W-1:srzp_pkg::REL_W]};
  assign tol_info.stale = stale_r;
  assign tol_info.tolerance = tol_sum[srzp_pkg::VAL_W] ? '1 : tol_sum[srzp_pkg::VAL_W-1:0];

endmodule

@@ rtl/srzp_emit.sv @@
// ---------------------------------------------------------------------------
// srzp_emit: filter decision, kept count and result queue
// Decides kept entries and row pointers, queues up to two results per item.
// ---------------------------------------------------------------------------
module srzp_emit #(
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_vld,
  input  srzp_pkg::item_t                     item,
  input  srzp_pkg::tol_info_t                 tol_info,
  input  logic                                one_based,
  output logic                                fire,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [srzp_pkg::OUT_DATA_W-1:0]     out_tdata,  // kept_value, kept_column, row_pointer
  output logic                                out_tuser,  // kind
  output logic                                out_tlast
);

  localparam int unsigned KW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = (KW + 1 > srzp_pkg::PTR_W) ? KW + 1 : srzp_pkg::PTR_W;
  localparam int unsigned PAD_W = srzp_pkg::OUT_DATA_W - srzp_pkg::VAL_W
                                  - srzp_pkg::COL_W - srzp_pkg::PTR_W;

  logic [KW-1:0] kept_r, kept_nxt, kept_base;
  logic [1:0] cnt_r, cnt_nxt, rem, n_res;
  srzp_pkg::result_t q0_r, q1_r, q0_nxt, q1_nxt;
  srzp_pkg::result_t res_entry, res_ptr, res_a;
  logic [SW-1:0] ptr_sum;
  logic is_filter, keep, pop, room;

  // filter decision
  always_comb begin
    is_filter = (item.mode == srzp_pkg::MODE_FILTER);
    kept_base = item.first ? '0 : kept_r;
    keep = item.has_entry && (item.magnitude > tol_info.tolerance) &&
           (kept_base < KW'(MAX_ENTRIES));
    kept_nxt = kept_base + KW'(keep);
    ptr_sum = SW'(kept_nxt) + SW'(one_based);
    n_res = is_filter ? (2'(keep) + 2'(item.row_end)) : 2'd0;
  end

  // result records
  always_comb begin
    res_entry.kind = srzp_pkg::KIND_ENTRY;
    res_entry.kept_value = item.entry_value;
    res_entry.kept_column = item.column_index;
    res_entry.row_pointer = '0;
    res_entry.last = !item.row_end;
    res_ptr.kind = srzp_pkg::KIND_ROWPTR;
    res_ptr.kept_value = '0;
    res_ptr.kept_column = '0;
    res_ptr.row_pointer = ptr_sum[srzp_pkg::PTR_W-1:0];
    res_ptr.last = 1'b1;
    res_a = keep ? res_entry : res_ptr;
  end

  // item leaves when the queue has room and, for a filter item, the tolerance is current
  always_comb begin
    pop = (cnt_r != 2'd0) && out_tready;
    rem = cnt_r - 2'(pop);
    room = ({1'b0, rem} + {1'b0, n_res}) <= 3'd2;
    fire = item_vld && room && (!is_filter || !tol_info.stale);
  end

  // two-slot queue, head in slot zero
  always_comb begin
    q0_nxt = pop ? q1_r : q0_r;
    q1_nxt = q1_r;
    if (fire) begin
      case (rem)
        2'd0: begin
          q0_nxt = res_a;
          q1_nxt = res_ptr;
        end
        2'd1: begin
          q1_nxt = res_a;
        end
        default: begin
          q1_nxt = q1_r;
        end
      endcase
    end
    cnt_nxt = rem + (fire ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      kept_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fire && is_filter) begin
        kept_r <= kept_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  // result port
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata = {{PAD_W{1'b0}}, q0_r.row_pointer, q0_r.kept_column, q0_r.kept_value};
  assign out_tuser = q0_r.kind;
  assign out_tlast = q0_r.last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue overflow");

  a_no_stale_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_filter) |-> !tol_info.stale)
    else $error("filter item used a stale tolerance");

  a_kept_cap: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= KW'(MAX_ENTRIES))
    else $error("kept count above capacity");

  a_scan_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_filter && !pop) |=> (cnt_r == $past(cnt_r)))
    else $error("scan item produced a result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

@@ rtl/sparse_row_zero_pruner_unit.sv @@
// ---------------------------------------------------------------------------
// sparse_row_zero_pruner_unit: drops small entries from a streamed CSR matrix
//
// The matrix is sent twice on the in_ stream. Items with mode 0 (scan) only
// track the largest magnitude; items with mode 1 (filter) emit each entry
// whose magnitude is above abs + rel * max, and a row pointer item on every
// row end. first clears the state of its pass. Results leave on the out_
// stream, tuser giving the kind and tlast marking the last result of an item.
// Configuration is written through cfg_we / cfg_index / cfg_wdata while idle.
// An accepted item is held in the input register, and its results are
// registered in the result queue before they show on out_.
// Throughput: one item per cycle while the result queue has room; an item
// with a kept entry and a row end gives two results for the single result
// port. The first filter item right after the maximum changes waits for
// the product register. Reset clears the configuration, maximum and kept
// count and empties the queue. When out_tready is low the two-slot queue and
// the skid slot fill, then in_tready drops; nothing is lost.
// ---------------------------------------------------------------------------
module sparse_row_zero_pruner_unit #(
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [srzp_pkg::IN_DATA_W-1:0]      in_tdata,  // entry_value, column_index
  input  logic [2:0]                          in_tuser,  // mode, first, has_entry
  input  logic                                in_tlast,  // row_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [srzp_pkg::OUT_DATA_W-1:0]     out_tdata, // kept_value, kept_column, row_pointer
  output logic                                out_tuser, // kind
  output logic                                out_tlast, // last
  input  logic                                cfg_we,
  input  logic [srzp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srzp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [srzp_pkg::ABS_W-1:0] abs_tol_r;
  logic [srzp_pkg::REL_W-1:0] rel_tol_r;
  logic one_based_r;
  logic item_vld, fire, scan_fire;
  srzp_pkg::item_t item;
  srzp_pkg::tol_info_t tol_info;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_tol_r <= '0;
      rel_tol_r <= '0;
      one_based_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        srzp_pkg::REG_ABS_TOL: abs_tol_r <= cfg_wdata;
        srzp_pkg::REG_REL_TOL: rel_tol_r <= cfg_wdata[srzp_pkg::REL_W-1:0];
        srzp_pkg::REG_ONE_BASED: one_based_r <= cfg_wdata[0];
        default: begin
          abs_tol_r <= abs_tol_r;
        end
      endcase
    end
  end

  srzp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .take      (fire),
    .item_vld  (item_vld),
    .item      (item)
  );

  assign scan_fire = fire && (item.mode == srzp_pkg::MODE_SCAN);

  srzp_tol_unit u_tol (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan_fire (scan_fire),
    .item      (item),
    .abs_tol   (abs_tol_r),
    .rel_tol   (rel_tol_r),
    .cfg_we    (cfg_we),
    .tol_info  (tol_info)
  );

  srzp_emit #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .item       (item),
    .tol_info   (tol_info),
    .one_based  (one_based_r),
    .fire       (fire),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for sparse_row_zero_pruner_unit
// Streams scan and filter passes of random CSR matrices plus noise items,
// predicts the kept entries and row pointers in the bench itself and checks
// each result item in order. Both stream sides idle at random, and the
// configuration changes only between passes, with the block drained.
// ---------------------------------------------------------------------------
module testbench;

  localparam int ROW_CAP = 65536;       // capacity of the block
  localparam int ITEM_TARGET = 1050;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int TOL_W = srzp_pkg::PROD_W + 1;

  // one matrix item as the bench sees it
  typedef struct packed {
    logic mode;
    logic first;
    logic has_entry;
    logic [srzp_pkg::VAL_W-1:0] value;
    logic [srzp_pkg::COL_W-1:0] col;
    logic row_end;
  } matrix_item_t;

  // directed row: register write or item, with results typed in where obvious
  typedef struct {
    bit is_cfg;
    logic [srzp_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [srzp_pkg::CFG_DATA_W-1:0] reg_val;
    matrix_item_t it;
    int typed_n;
    srzp_pkg::result_t r0;
    srzp_pkg::result_t r1;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [srzp_pkg::IN_DATA_W-1:0] in_tdata = '0;    // entry_value, column_index
  logic [2:0] in_tuser = '0;                        // mode, first, has_entry
  logic in_tlast = 1'b0;                            // row_end
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [srzp_pkg::OUT_DATA_W-1:0] out_tdata;       // kept_value, kept_column, row_pointer
  logic out_tuser;                                  // kind
  logic out_tlast;                                  // last
  logic cfg_we = 1'b0;
  logic [srzp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [srzp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state and register copies
  logic [srzp_pkg::VAL_W-1:0] max_mag = '0;
  logic [srzp_pkg::PTR_W-1:0] kept_cnt = '0;
  logic [srzp_pkg::ABS_W-1:0] abs_tol_q = '0;
  logic [srzp_pkg::REL_W-1:0] rel_tol_q = '0;
  logic one_based_q = 1'b0;

  srzp_pkg::result_t pending_results[$];
  matrix_item_t matrix_q[$];
  dir_row_t dir_tab[$];
  int err_cnt = 0;
  int sent_cnt = 0;
  int rx_done_cnt = 0;
  int rx_gap = 0;
  int quiet_cycles = 0;
  bit rx_fast = 1'b0;
  bit tx_fast = 1'b0;

  sparse_row_zero_pruner_unit #(.MAX_ENTRIES(ROW_CAP)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic srzp_pkg::result_t kept_entry(logic [srzp_pkg::VAL_W-1:0] v,
                                                   logic [srzp_pkg::COL_W-1:0] c, logic l);
    srzp_pkg::result_t r;
    r = '0;
    r.kind = srzp_pkg::KIND_ENTRY;
    r.kept_value = v;
    r.kept_column = c;
    r.last = l;
    return r;
  endfunction

  function automatic srzp_pkg::result_t row_ptr(logic [srzp_pkg::PTR_W-1:0] p, logic l);
    srzp_pkg::result_t r;
    r = '0;
    r.kind = srzp_pkg::KIND_ROWPTR;
    r.row_pointer = p;
    r.last = l;
    return r;
  endfunction

  function automatic dir_row_t d_item(logic mode, logic first, logic has,
                                      logic [srzp_pkg::VAL_W-1:0] v,
                                      logic [srzp_pkg::COL_W-1:0] c, logic re, int n,
                                      srzp_pkg::result_t r0, srzp_pkg::result_t r1);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.reg_idx = '0;
    d.reg_val = '0;
    d.it = '{mode: mode, first: first, has_entry: has, value: v, col: c, row_end: re};
    d.typed_n = n;
    d.r0 = r0;
    d.r1 = r1;
    return d;
  endfunction

  function automatic dir_row_t d_cfg(logic [srzp_pkg::CFG_IDX_W-1:0] idx,
                                     logic [srzp_pkg::CFG_DATA_W-1:0] v);
    dir_row_t d;
    d.is_cfg = 1'b1;
    d.reg_idx = idx;
    d.reg_val = v;
    d.it = '0;
    d.typed_n = 0;
    d.r0 = '0;
    d.r1 = '0;
    return d;
  endfunction

  // kept entries and row pointer caused by one item; updates the pass state
  function automatic int predict_pruned(input matrix_item_t it, output srzp_pkg::result_t r0,
                                        output srzp_pkg::result_t r1);
    logic [srzp_pkg::VAL_W-1:0] mag;
    logic [TOL_W-1:0] tol;
    logic [TOL_W-1:0] prod;
    srzp_pkg::result_t res[2];
    int n;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    mag = it.value[srzp_pkg::VAL_W-1] ? (~it.value + 32'd1) : it.value;
    if (it.mode == srzp_pkg::MODE_SCAN) begin
      if (it.first) max_mag = '0;
      if (it.has_entry && mag > max_mag) max_mag = mag;
    end else begin
      if (it.first) kept_cnt = '0;
      tol = TOL_W'(abs_tol_q);
      if (rel_tol_q != '0) begin
        prod = TOL_W'(rel_tol_q) * TOL_W'(max_mag);
        tol = tol + (prod >> 16);
      end
      if (tol > TOL_W'(32'hFFFF_FFFF)) tol = TOL_W'(32'hFFFF_FFFF);
      if (it.has_entry && mag > tol && kept_cnt < srzp_pkg::PTR_W'(ROW_CAP)) begin
        res[n] = kept_entry(it.value, it.col, 1'b0);
        n++;
        kept_cnt++;
      end
      if (it.row_end) begin
        res[n] = row_ptr(kept_cnt + srzp_pkg::PTR_W'(one_based_q), 1'b0);
        n++;
      end
      if (n > 0) res[n-1].last = 1'b1;
    end
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  // value mix: full range, near zero, extremes, mid range
  function automatic logic [srzp_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1, 2: return $urandom_range(0, 32'h60000) - 32'h30000;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(0, 32'h200_0000) - 32'h100_0000;
    endcase
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // offer one item, wait for the handshake, queue its expected results
  task automatic send_item(input matrix_item_t it, input int typed_n,
                           input srzp_pkg::result_t t0, input srzp_pkg::result_t t1);
    int gap;
    int n;
    srzp_pkg::result_t p0;
    srzp_pkg::result_t p1;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.col, it.value};
    in_tuser <= {it.has_entry, it.first, it.mode};
    in_tlast <= it.row_end;
    do @(posedge clk); while (!in_tready);
    n = predict_pruned(it, p0, p1);
    if (typed_n >= 0) begin
      n = typed_n;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) pending_results.push_back(p0);
    if (n > 1) pending_results.push_back(p1);
    sent_cnt++;
  endtask

  // stop offering, let every expected result arrive and the pipe empty
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [srzp_pkg::CFG_IDX_W-1:0] idx,
                           logic [srzp_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srzp_pkg::REG_ABS_TOL: abs_tol_q = v;
      srzp_pkg::REG_REL_TOL: rel_tol_q = v[srzp_pkg::REL_W-1:0];
      srzp_pkg::REG_ONE_BASED: one_based_q = v[0];
      default: ;
    endcase
  endtask

  task automatic shuffle_config();
    logic [srzp_pkg::CFG_DATA_W-1:0] v;
    wait_idle();
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = 31'h7FFF_FFFF;
        2: v = srzp_pkg::CFG_DATA_W'($urandom_range(0, 32'h40000));
        default: v = srzp_pkg::CFG_DATA_W'($urandom);
      endcase
      write_reg(srzp_pkg::REG_ABS_TOL, v);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = 31'h0000_FFFF;
        2: v = srzp_pkg::CFG_DATA_W'($urandom_range(1, 16'h2000));
        default: v = srzp_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF));
      endcase
      write_reg(srzp_pkg::REG_REL_TOL, v);
    end
    if ($urandom_range(0, 1)) begin
      write_reg(srzp_pkg::REG_ONE_BASED, srzp_pkg::CFG_DATA_W'($urandom_range(0, 1)));
    end
  endtask

  // random CSR matrix in row order; empty rows are closing-only items
  task automatic build_matrix();
    int rows;
    int k;
    matrix_item_t it;
    matrix_q.delete();
    rows = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    for (int r = 0; r < rows; r++) begin
      k = $urandom_range(0, 4);
      if (k == 0) begin
        it = '{mode: srzp_pkg::MODE_FILTER, first: 1'b0, has_entry: 1'b0, value: $urandom,
               col: 16'($urandom), row_end: 1'b1};
        matrix_q.push_back(it);
      end
      for (int e = 0; e < k; e++) begin
        it = '{mode: srzp_pkg::MODE_FILTER, first: 1'b0, has_entry: 1'b1,
               value: pick_value(), col: 16'($urandom), row_end: (e == k - 1)};
        matrix_q.push_back(it);
      end
    end
  endtask

  task automatic send_pass(logic mode, bit with_first, int count);
    matrix_item_t it;
    for (int i = 0; i < count; i++) begin
      it = matrix_q[i];
      it.mode = mode;
      it.first = with_first && (i == 0);
      send_item(it, -1, '0, '0);
    end
  endtask

  // result checking at the rising edge
  always @(posedge clk) begin : result_check
    srzp_pkg::result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none actual %h %h %h", $time,
                 out_tuser, out_tdata, out_tlast);
      end else begin
        exp_r = pending_results.pop_front();
        compare_field("kind", 64'(exp_r.kind), 64'(out_tuser));
        compare_field("kept_value", 64'($unsigned(exp_r.kept_value)),
                      64'(out_tdata[srzp_pkg::VAL_W-1:0]));
        compare_field("kept_column", 64'(exp_r.kept_column),
                      64'(out_tdata[srzp_pkg::VAL_W+srzp_pkg::COL_W-1:srzp_pkg::VAL_W]));
        compare_field("row_pointer", 64'(exp_r.row_pointer),
                      64'(out_tdata[srzp_pkg::VAL_W+srzp_pkg::COL_W+srzp_pkg::PTR_W-1:
                                    srzp_pkg::VAL_W+srzp_pkg::COL_W]));
        compare_field("last", 64'(exp_r.last), 64'(out_tlast));
      end
    end
  end

  // result sink: random ready gaps, occasional long hold
  initial begin : result_sink
    bit took;
    forever begin
      @(posedge clk);
      took = rst_n && out_tvalid && out_tready;
      @(negedge clk);
      if (took) begin
        rx_done_cnt++;
        if (rx_done_cnt % 50 == 0) rx_fast = ($urandom_range(0, 2) == 0);
        rx_gap = rx_fast ? 0 : $urandom_range(0, 19);
        if (rx_done_cnt == 120 || rx_done_cnt == 400) begin
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
        end
      end
      if (rx_gap > 0) begin
        out_tready <= 1'b0;
        rx_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int choice;
    int cut;
    // filter before any scan, extremes of value and column, row end without entry
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b1, 1'b1, 32'h0, 16'h0, 1'b0, 0,
                             '0, '0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b1, 32'h7FFF_FFFF, 16'hFFFF,
                             1'b1, 2, kept_entry(32'h7FFF_FFFF, 16'hFFFF, 1'b0),
                             row_ptr(17'd1, 1'b1)));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b1, 32'h8000_0000, 16'h0,
                             1'b0, 1, kept_entry(32'h8000_0000, 16'h0, 1'b1), '0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF,
                             1'b1, 1, row_ptr(17'd2, 1'b1), '0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'h1234,
                             1'b1, 2, kept_entry(32'hFFFF_FFFF, 16'h1234, 1'b0),
                             row_ptr(17'd3, 1'b1)));
    // scan with the most negative value; row end ignored there
    dir_tab.push_back(d_item(srzp_pkg::MODE_SCAN, 1'b1, 1'b1, 32'h8000_0000, 16'h0, 1'b1,
                             0, '0, '0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_SCAN, 1'b0, 1'b1, 32'h7FFF_FFFF, 16'h0, 1'b0,
                             0, '0, '0));
    // largest tolerance drops everything
    dir_tab.push_back(d_cfg(srzp_pkg::REG_REL_TOL, 31'h0000_FFFF));
    dir_tab.push_back(d_cfg(srzp_pkg::REG_ABS_TOL, 31'h7FFF_FFFF));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b1, 1'b1, 32'h8000_0000, 16'h00FF,
                             1'b1, 1, row_ptr(17'd0, 1'b1), '0));
    // relative part alone, entries on both sides of the bound
    dir_tab.push_back(d_cfg(srzp_pkg::REG_ABS_TOL, 31'h0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b1, 32'h7FFF_8000, 16'h2, 1'b0,
                             -1, '0, '0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b1, 32'h7FFF_8001, 16'h3, 1'b0,
                             -1, '0, '0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b1, 32'h8000_8000, 16'h4, 1'b0,
                             -1, '0, '0));
    dir_tab.push_back(d_cfg(srzp_pkg::REG_ONE_BASED, 31'd1));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b0, 32'h0, 16'h0, 1'b1,
                             -1, '0, '0));
    // absolute part alone, magnitude equal to the tolerance is dropped
    dir_tab.push_back(d_cfg(srzp_pkg::REG_REL_TOL, 31'h0));
    dir_tab.push_back(d_cfg(srzp_pkg::REG_ABS_TOL, 31'h0001_0000));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b1, 1'b1, 32'h0001_0000, 16'h7, 1'b0,
                             0, '0, '0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b1, 32'hFFFF_0000, 16'h8, 1'b1,
                             1, row_ptr(17'd1, 1'b1), '0));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b0, 1'b1, 32'h0001_0001, 16'h9, 1'b1,
                             2, kept_entry(32'h0001_0001, 16'h9, 1'b0),
                             row_ptr(17'd2, 1'b1)));
    // scan cleared by a closing-only first item, maximum back to zero
    dir_tab.push_back(d_item(srzp_pkg::MODE_SCAN, 1'b1, 1'b0, 32'h7FFF_FFFF, 16'hFFFF,
                             1'b1, 0, '0, '0));
    dir_tab.push_back(d_cfg(srzp_pkg::REG_REL_TOL, 31'h0000_8000));
    dir_tab.push_back(d_item(srzp_pkg::MODE_FILTER, 1'b1, 1'b1, 32'hFFFE_FFFF, 16'hA, 1'b1,
                             -1, '0, '0));
    dir_tab.push_back(d_cfg(srzp_pkg::REG_ONE_BASED, 31'd0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_item(dir_tab[i].it, dir_tab[i].typed_n, dir_tab[i].r0, dir_tab[i].r1);
      end
    end

    // random phases: mostly scan then filter of one matrix, some broken or noise
    while (sent_cnt < ITEM_TARGET) begin
      choice = $urandom_range(0, 9);
      if ($urandom_range(0, 4) == 0) shuffle_config();
      tx_fast = ($urandom_range(0, 2) == 0);
      if (choice < 8) begin
        build_matrix();
        if ($urandom_range(0, 9) != 0) begin
          send_pass(srzp_pkg::MODE_SCAN, 1'b1, matrix_q.size());
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, matrix_q.size())
                                          : matrix_q.size();
        send_pass(srzp_pkg::MODE_FILTER, $urandom_range(0, 9) != 0, cut);
      end else begin
        repeat ($urandom_range(5, 15)) begin
          send_item('{mode: 1'($urandom_range(0, 1)), first: ($urandom_range(0, 3) == 0),
                      has_entry: 1'($urandom_range(0, 1)), value: $urandom,
                      col: 16'($urandom), row_end: 1'($urandom_range(0, 1))},
                    -1, '0, '0);
        end
      end
      if ($urandom_range(0, 3) == 0) wait_idle();
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/srzp_pkg.sv
rtl/srzp_in_stage.sv
rtl/srzp_tol_unit.sv
rtl/srzp_emit.sv
rtl/sparse_row_zero_pruner_unit.sv
dv/testbench.sv
